@@ rtl/hebc_pkg.sv @@
// hebc_pkg: shared types and constants for the hit event builder / calibrator.
// No dependencies; imported by every module under rtl/.
package hebc_pkg;

   localparam int DEFAULT_MODULES   = 16;
   localparam int DEFAULT_CHANNELS  = 16;
   localparam int DEFAULT_TIME_BITS = 48;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 160;

   localparam logic [31:0] WINDOW_RESET   = 32'd1000;
   localparam logic [3:0]  ALT_FIRMWARE   = 4'd4;
   localparam logic [15:0] DETECTOR_RESET = 16'hFFFF;
   localparam logic [15:0] DET_ID_RESET   = 16'hFFFF;

   typedef enum logic [2:0] {
      FUNC_HIT    = 3'd0,
      FUNC_WR_DET = 3'd1,
      FUNC_WR_ID  = 3'd2,
      FUNC_WR_A0  = 3'd3,
      FUNC_WR_A1  = 3'd4,
      FUNC_WR_A2  = 3'd5
   } func_type;

   typedef struct packed {
      logic det;
      logic det_id;
      logic a0;
      logic a1;
      logic a2;
   } tbl_wr_type;

   typedef struct packed {
      logic [15:0]        detector;
      logic [15:0]        det_id;
      logic signed [47:0] a0;
      logic signed [47:0] a1;
      logic signed [47:0] a2;
   } tbl_entry_type;

endpackage

@@ rtl/hebc_tables.sv @@
// hebc_tables: per-channel detector map and calibration coefficient memories,
// one write and one registered read port, with a clearing pass after reset. Uses hebc_pkg.
module hebc_tables import hebc_pkg::*; #(
   parameter int ENTRIES = DEFAULT_MODULES * DEFAULT_CHANNELS,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  tbl_wr_type       wr,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [47:0]      wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output tbl_entry_type    rd_entry,
   output logic             tbl_ready
);

   logic [15:0] det_mem [ENTRIES];
   logic [15:0] id_mem  [ENTRIES];
   logic [47:0] a0_mem  [ENTRIES];
   logic [47:0] a1_mem  [ENTRIES];
   logic [47:0] a2_mem  [ENTRIES];

   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] addr;

   assign addr      = clearing_ff ? clr_ff : wr_idx;
   assign tbl_ready = !clearing_ff;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == IDX_W'(ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff || wr.det) begin
         det_mem[addr] <= clearing_ff ? DETECTOR_RESET : wr_data[15:0];
      end
      if (clearing_ff || wr.det_id) begin
         id_mem[addr] <= clearing_ff ? DET_ID_RESET : wr_data[15:0];
      end
      if (clearing_ff || wr.a0) begin
         a0_mem[addr] <= clearing_ff ? 48'd0 : wr_data;
      end
      if (clearing_ff || wr.a1) begin
         a1_mem[addr] <= clearing_ff ? 48'd0 : wr_data;
      end
      if (clearing_ff || wr.a2) begin
         a2_mem[addr] <= clearing_ff ? 48'd0 : wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry.detector <= det_mem[rd_idx];
      rd_entry.det_id   <= id_mem[rd_idx];
      rd_entry.a0       <= a0_mem[rd_idx];
      rd_entry.a1       <= a1_mem[rd_idx];
      rd_entry.a2       <= a2_mem[rd_idx];
   end

endmodule

@@ rtl/hebc_calib.sv @@
// hebc_calib: quadratic calibration a0 + x*(a1 + a2*x) on one shared 33x33 signed
// multiplier, stepped by a small sequencer; round to nearest and saturate. Uses hebc_pkg.
module hebc_calib import hebc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] a0,
   input  logic signed [47:0] a1,
   input  logic signed [47:0] a2,
   input  logic [31:0]        x,
   output logic               busy,
   output logic               done,
   output logic [47:0]        result
);

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_M_A2L,
      CS_M_A2H,
      CS_ADD_A2H,
      CS_LOAD_A0,
      CS_M_T0,
      CS_M_T1,
      CS_M_T2,
      CS_ADD_T2,
      CS_SAT
   } step_type;

   localparam logic [127:0] ROUND_BIAS = 128'd1 << 39;

   step_type           step_ff, step_in;
   logic signed [47:0] a0_ff, a2_ff;
   logic [31:0]        x_ff;
   logic [127:0]       acc_ff;
   logic [95:0]        t_ff;
   logic signed [65:0] prod_ff;
   logic               done_ff;
   logic [47:0]        result_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [127:0]       prod_ext, addend, sum;
   logic [40:0]        top;
   logic               sat_neg, sat_pos;

   assign mul_b    = $signed({1'b0, x_ff});
   assign mul_p    = mul_a * mul_b;
   assign prod_ext = {{62{prod_ff[65]}}, prod_ff};
   assign sum      = acc_ff + addend;
   assign top      = acc_ff[127:87];
   assign sat_neg  = acc_ff[127] && (top != '1);
   assign sat_pos  = !acc_ff[127] && (top != '0);

   always_comb begin
      mul_a  = '0;
      addend = '0;
      unique case (step_ff)
         CS_M_A2L:   mul_a = $signed({1'b0, a2_ff[31:0]});
         CS_M_A2H: begin
            mul_a  = $signed({{17{a2_ff[47]}}, a2_ff[47:32]});
            addend = prod_ext;
         end
         CS_ADD_A2H: addend = prod_ext << 32;
         CS_M_T0:    mul_a = $signed({1'b0, t_ff[31:0]});
         CS_M_T1: begin
            mul_a  = $signed({1'b0, t_ff[63:32]});
            addend = prod_ext;
         end
         CS_M_T2: begin
            mul_a  = $signed({t_ff[95], t_ff[95:64]});
            addend = prod_ext << 32;
         end
         CS_ADD_T2:  addend = prod_ext << 64;
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (step_ff)
         CS_IDLE:    step_in = start ? CS_M_A2L : CS_IDLE;
         CS_M_A2L:   step_in = CS_M_A2H;
         CS_M_A2H:   step_in = CS_ADD_A2H;
         CS_ADD_A2H: step_in = CS_LOAD_A0;
         CS_LOAD_A0: step_in = CS_M_T0;
         CS_M_T0:    step_in = CS_M_T1;
         CS_M_T1:    step_in = CS_M_T2;
         CS_M_T2:    step_in = CS_ADD_T2;
         CS_ADD_T2:  step_in = CS_SAT;
         CS_SAT:     step_in = CS_IDLE;
         default:    step_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= CS_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= (step_ff == CS_SAT);
      end
      prod_ff <= mul_p;
      unique case (step_ff)
         CS_IDLE: begin
            if (start) begin
               a0_ff  <= a0;
               a2_ff  <= a2;
               x_ff   <= x;
               acc_ff <= {{64{a1[47]}}, a1, 16'd0};
            end
         end
         CS_LOAD_A0: begin
            t_ff   <= acc_ff[95:0];
            acc_ff <= {{48{a0_ff[47]}}, a0_ff, 32'd0} + ROUND_BIAS;
         end
         CS_SAT: begin
            if (sat_neg) begin
               result_ff <= 48'h8000_0000_0000;
            end else if (sat_pos) begin
               result_ff <= 48'h7FFF_FFFF_FFFF;
            end else begin
               result_ff <= acc_ff[87:40];
            end
         end
         default: acc_ff <= sum;
      endcase
   end

   assign busy   = (step_ff != CS_IDLE);
   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/hit_event_builder_calibrator.sv @@
// hit_event_builder_calibrator: top level; table writes, coincidence window event
// building and result register. Uses hebc_pkg, hebc_tables, hebc_calib.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: module, channel, timestamp, fw kind,
//                                       energy, energy_alt, dither, load_value; tuser: func
//   rsp      out  rsp_tvalid/tready     tdata: event index, detector, id, time, energy;
//                                       tuser: new_event
//   csr      in   csr_valid/csr_ready   csr_data: window_width
//
// A table write completes on acceptance; a hit on a disabled channel passes ST_READ and
// ST_EVAL with no result; an enabled hit also runs the five partial products of the
// shared 33x33 multiplier. After reset all MODULES*CHANNELS entries (256 by default)
// are cleared; req_tready stays low meanwhile, csr writes are taken.
// A result waits in the output register; the next transaction is accepted meanwhile,
// and only its result stalls until rsp_tready.
module hit_event_builder_calibrator import hebc_pkg::*; #(
   parameter int MODULES   = DEFAULT_MODULES,
   parameter int CHANNELS  = DEFAULT_CHANNELS,
   parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] module_req, [7:4] channel, [55:8] timestamp, [59:56] firmware_kind,
   // [75:60] energy, [91:76] energy_alt, [107:92] dither, [155:108] load_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] func
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] event_index, [46:32] detector, [62:47] detector_id,
   // [110:63] hit_time, [158:111] calibrated_energy
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] new_event
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);

   localparam int ENTRIES = MODULES * CHANNELS;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TS_W    = (TIME_BITS < 48) ? TIME_BITS : 48;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CALC,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [31:0]      window_ff;
   logic             event_open_ff;
   logic [TS_W-1:0]  start_ff;
   logic [31:0]      count_ff;
   logic             opened_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [31:0]      x_ff;
   logic [TS_W-1:0]  diff_ff;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   func_type         req_func;
   logic [3:0]       req_module, req_channel, req_fw;
   logic [47:0]      req_ts, req_load;
   logic [15:0]      req_energy, req_energy_alt, req_dither;
   logic             req_accept, in_range, hit_accept, rsp_free, in_window;
   logic [IDX_W-1:0] req_idx;
   tbl_wr_type       tbl_wr;
   tbl_entry_type    rd_entry;
   logic             tbl_ready;
   logic             calib_start, calib_busy, calib_done;
   logic [47:0]      calib_result;

   assign req_module     = req_tdata[3:0];
   assign req_channel    = req_tdata[7:4];
   assign req_ts         = req_tdata[55:8];
   assign req_fw         = req_tdata[59:56];
   assign req_energy     = req_tdata[75:60];
   assign req_energy_alt = req_tdata[91:76];
   assign req_dither     = req_tdata[107:92];
   assign req_load       = req_tdata[155:108];
   assign req_func       = func_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE) && tbl_ready;
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (32'(req_module) < MODULES) && (32'(req_channel) < CHANNELS);
   assign req_idx    = IDX_W'(32'(req_module) * CHANNELS + 32'(req_channel));
   assign hit_accept = req_accept && in_range && (req_func == FUNC_HIT);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign in_window  = 64'(diff_ff) <= 64'(window_ff);
   assign calib_start = (state_ff == ST_EVAL) && !rd_entry.detector[15];
   assign csr_ready  = 1'b1;

   always_comb begin
      tbl_wr = '0;
      if (req_accept && in_range) begin
         unique case (req_func)
            FUNC_WR_DET: tbl_wr.det    = 1'b1;
            FUNC_WR_ID:  tbl_wr.det_id = 1'b1;
            FUNC_WR_A0:  tbl_wr.a0     = 1'b1;
            FUNC_WR_A1:  tbl_wr.a1     = 1'b1;
            FUNC_WR_A2:  tbl_wr.a2     = 1'b1;
            default: begin
            end
         endcase
      end
   end

   hebc_tables #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_tables (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .wr_idx    (req_idx),
      .wr_data   (req_load),
      .rd_idx    (idx_ff),
      .rd_entry  (rd_entry),
      .tbl_ready (tbl_ready)
   );

   hebc_calib u_calib (
      .clock  (clock),
      .reset  (reset),
      .start  (calib_start),
      .a0     (rd_entry.a0),
      .a1     (rd_entry.a1),
      .a2     (rd_entry.a2),
      .x      (x_ff),
      .busy   (calib_busy),
      .done   (calib_done),
      .result (calib_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         window_ff     <= WINDOW_RESET;
         event_open_ff <= 1'b0;
         start_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (tbl_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (hit_accept) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               diff_ff  <= (ts_ff > start_ff) ? ts_ff - start_ff : start_ff - ts_ff;
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (rd_entry.detector[15]) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_CALC;
                  if (!event_open_ff) begin
                     event_open_ff <= 1'b1;
                     start_ff      <= ts_ff;
                     opened_ff     <= 1'b1;
                  end else if (!in_window) begin
                     count_ff  <= count_ff + 32'd1;
                     start_ff  <= ts_ff;
                     opened_ff <= 1'b1;
                  end else begin
                     opened_ff <= 1'b0;
                  end
               end
            end
            ST_CALC: begin
               if (calib_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= opened_ff;
                  rsp_data_ff  <= {1'b0, calib_result, 48'(ts_ff), rd_entry.det_id,
                                   rd_entry.detector[14:0], count_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (hit_accept) begin
         idx_ff <= req_idx;
         ts_ff  <= req_ts[TS_W-1:0];
         x_ff   <= {(req_fw == ALT_FIRMWARE) ? req_energy_alt : req_energy, req_dither};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 32'd1))
      else $error("event index jumped");

   a_open_sticky: assert property (@(posedge clock) disable iff (reset)
      event_open_ff |=> event_open_ff)
      else $error("event closed without reset");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !calib_busy)
      else $error("transaction accepted during calibration");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      calib_start |-> !calib_busy)
      else $error("calibration started while busy");

endmodule
